>>> hw/rtl/bdee_pkg.sv
// Shared types and constants for the button debounce event encoder.
// Holds the button key map, field widths and configuration codes.
// No dependencies.
`timescale 1ns / 1ps

package bdee_pkg;

  // Sizing
  localparam int NUM_BUTTONS = 6;
  localparam int TIME_BITS   = 32;
  localparam int MAP_SIZE    = 6;
  localparam int MASK_W      = NUM_BUTTONS + 1;   // one bit per button plus heartbeat

  // Field widths
  localparam int DEB_W   = 16;
  localparam int HB_W    = 20;
  localparam int IDX_W   = 3;
  localparam int SERVO_W = 8;
  localparam int DIR_W   = 2;
  localparam int COLOR_W = 24;

  // Elapsed-time compare width covers the timestamp and the widest register
  localparam int CMP_W = (TIME_BITS > HB_W) ? TIME_BITS : HB_W;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = HB_W;
  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEARTBEAT = 2'd1;

  localparam logic [DEB_W-1:0] DEBOUNCE_RESET  = 16'd50;
  localparam logic [HB_W-1:0]  HEARTBEAT_RESET = 20'd5000;

  // Result codes
  localparam logic KIND_BUTTON    = 1'b0;
  localparam logic KIND_HEARTBEAT = 1'b1;
  localparam logic [SERVO_W-1:0] HB_SERVO = 8'd255;
  localparam logic [DIR_W-1:0]   DIR_STOP = 2'b00;
  localparam logic [DIR_W-1:0]   DIR_CW   = 2'b01;
  localparam logic [DIR_W-1:0]   DIR_CCW  = 2'b11;

  typedef struct packed {
    logic [SERVO_W-1:0] servo;
    logic [DIR_W-1:0]   dir;
    logic [COLOR_W-1:0] color;
  } key_entry_t;

  // Decisions of one poll handed to the output serializer
  typedef struct packed {
    logic [MASK_W-1:0]      mask;      // accepted changes, heartbeat on top bit
    logic [NUM_BUTTONS-1:0] pressed;   // new level of each button
  } emit_load_t;

  // Fixed button map: servo, direction on press, colour on press
  function automatic key_entry_t key_map(input logic [IDX_W-1:0] key);
    key_entry_t e;
    case (key)
      3'd0:    e = '{servo: 8'd0, dir: DIR_CCW, color: 24'hFF0000};
      3'd1:    e = '{servo: 8'd0, dir: DIR_CW,  color: 24'h00FF00};
      3'd2:    e = '{servo: 8'd1, dir: DIR_CCW, color: 24'h0000FF};
      3'd3:    e = '{servo: 8'd1, dir: DIR_CW,  color: 24'hFFFF00};
      3'd4:    e = '{servo: 8'd2, dir: DIR_CCW, color: 24'hFF00FF};
      3'd5:    e = '{servo: 8'd2, dir: DIR_CW,  color: 24'h00FFFF};
      default: e = '{servo: 8'd0, dir: DIR_STOP, color: 24'h000000};
    endcase
    return e;
  endfunction

endpackage

>>> hw/rtl/button_debounce_event_encoder.sv
// Latency: a poll taken at one edge is judged in the input register; its first result
// is shown the cycle after it is judged. Results leave one per cycle unless stalled,
// lowest button first, heartbeat last. Throughput, unstalled: one poll per cycle with
// at most one result each; more results (up to 7) hold the serializer until the last.
// Reset (synchronous, rst_n low): debounce 50 ms, heartbeat 5000 ms, all buttons
// released, all change and heartbeat times zero, no result pending.
`timescale 1ns / 1ps

// Top level: input register, per-button lockout decision and state, config registers.
// Depends on bdee_pkg and bdee_emit.
module button_debounce_event_encoder (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // Configuration write port
  input  logic                                  cfg_we,
  input  logic [bdee_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [bdee_pkg::CFG_DATA_W-1:0]       cfg_data,
  // Poll requests
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [bdee_pkg::TIME_BITS-1:0]        in_time_now,
  input  logic [bdee_pkg::NUM_BUTTONS-1:0]      in_raw_levels,
  // Command results
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic                                  out_kind,
  output logic [bdee_pkg::IDX_W-1:0]            out_button_index,
  output logic [bdee_pkg::SERVO_W-1:0]          out_servo_id,
  output logic signed [bdee_pkg::DIR_W-1:0]     out_direction,
  output logic [bdee_pkg::COLOR_W-1:0]          out_led_color,
  output logic                                  out_last
);

  localparam int NB = bdee_pkg::NUM_BUTTONS;
  localparam int TB = bdee_pkg::TIME_BITS;
  localparam int CW = bdee_pkg::CMP_W;

  // Configuration
  logic [bdee_pkg::DEB_W-1:0] debounce_r;
  logic [bdee_pkg::HB_W-1:0]  heartbeat_r;

  // Input register
  logic          s1_valid_r;
  logic [TB-1:0] s1_time_r;
  logic [NB-1:0] s1_levels_r;

  // Debounce state
  logic [NB-1:0] held_r;
  logic [TB-1:0] change_time_r [NB];
  logic [TB-1:0] hb_time_r;

  logic [NB-1:0] pressed;
  logic [NB-1:0] accept;
  logic [TB-1:0] hb_elapsed;
  logic          hb_due;
  logic          s1_fire;
  logic          load_ready;
  bdee_pkg::emit_load_t load;

  // Configuration writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r  <= bdee_pkg::DEBOUNCE_RESET;
      heartbeat_r <= bdee_pkg::HEARTBEAT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        bdee_pkg::CFG_DEBOUNCE:  debounce_r  <= cfg_data[bdee_pkg::DEB_W-1:0];
        bdee_pkg::CFG_HEARTBEAT: heartbeat_r <= cfg_data[bdee_pkg::HB_W-1:0];
        default: ;
      endcase
    end
  end

  // Input register refills as the held poll moves on
  assign in_ready = !s1_valid_r || load_ready;
  assign s1_fire  = s1_valid_r && load_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_time_r   <= in_time_now;
      s1_levels_r <= in_raw_levels;
    end
  end

  // Per-button lockout check, all buttons in parallel
  assign pressed = ~s1_levels_r;
  for (genvar g = 0; g < NB; g++) begin : g_btn
    logic [TB-1:0] elapsed;
    assign elapsed   = s1_time_r - change_time_r[g];
    assign accept[g] = (pressed[g] != held_r[g]) &&
                       (CW'(elapsed) > CW'(debounce_r));
  end

  // Accepted changes take the new level and the poll's time
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r <= '0;
      for (int i = 0; i < NB; i++) begin
        change_time_r[i] <= '0;
      end
    end else if (s1_fire) begin
      for (int i = 0; i < NB; i++) begin
        if (accept[i]) begin
          held_r[i]        <= pressed[i];
          change_time_r[i] <= s1_time_r;
        end
      end
    end
  end

  // Heartbeat check
  assign hb_elapsed = s1_time_r - hb_time_r;
  assign hb_due     = CW'(hb_elapsed) > CW'(heartbeat_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hb_time_r <= '0;
    end else if (s1_fire && hb_due) begin
      hb_time_r <= s1_time_r;
    end
  end

  assign load = '{mask: {hb_due, accept}, pressed: pressed};

  bdee_emit u_emit (
    .clk              (clk),
    .rst_n            (rst_n),
    .load_valid       (s1_valid_r),
    .load             (load),
    .load_ready       (load_ready),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_kind         (out_kind),
    .out_button_index (out_button_index),
    .out_servo_id     (out_servo_id),
    .out_direction    (out_direction),
    .out_led_color    (out_led_color),
    .out_last         (out_last)
  );

`ifndef SYNTH
  // An accepted heartbeat restarts the interval at the poll's time
  a_hb_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && hb_due) |=> hb_time_r == $past(s1_time_r))
    else $error("heartbeat time not updated");

  // An accepted change on button 0 takes the new level and time
  a_btn0_update: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && accept[0]) |=> (held_r[0] == !$past(s1_levels_r[0])) &&
                               (change_time_r[0] == $past(s1_time_r)))
    else $error("button 0 state not updated");

  // Rejected changes leave button 0 untouched
  a_btn0_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !(s1_fire && accept[0]) |=> $stable(held_r[0]) && $stable(change_time_r[0]))
    else $error("button 0 state changed without accept");
`endif

endmodule

>>> hw/rtl/bdee_emit.sv
// Output serializer: walks the accepted-change mask of one poll, lowest first.
// Depends on bdee_pkg.
`timescale 1ns / 1ps

module bdee_emit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              load_valid,
  input  bdee_pkg::emit_load_t              load,
  output logic                              load_ready,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              out_kind,
  output logic [bdee_pkg::IDX_W-1:0]        out_button_index,
  output logic [bdee_pkg::SERVO_W-1:0]      out_servo_id,
  output logic signed [bdee_pkg::DIR_W-1:0] out_direction,
  output logic [bdee_pkg::COLOR_W-1:0]      out_led_color,
  output logic                              out_last
);

  localparam int NB = bdee_pkg::NUM_BUTTONS;
  localparam int MW = bdee_pkg::MASK_W;

  logic [MW-1:0]  pend_r, pend_nxt;
  logic [NB-1:0]  pressed_r;
  logic [MW-1:0]  lowest;
  logic [MW-1:0]  rest;
  logic           out_fire;
  logic           load_fire;
  bdee_pkg::key_entry_t map_c [NB];
  logic [bdee_pkg::DIR_W-1:0] dir_sel;

  // Constant key map per button, wrapping past the map size
  for (genvar g = 0; g < NB; g++) begin : g_map
    assign map_c[g] = bdee_pkg::key_map(bdee_pkg::IDX_W'(g % bdee_pkg::MAP_SIZE));
  end

  // Lowest pending request goes out first
  assign lowest    = pend_r & (~pend_r + MW'(1));
  assign rest      = pend_r & ~lowest;
  assign out_valid = |pend_r;
  assign out_last  = (rest == '0);
  assign out_fire  = out_valid && out_ready;
  assign load_ready = !out_valid || (out_ready && out_last);
  assign load_fire  = load_valid && load_ready;

  // Field select for the lowest pending bit
  always_comb begin
    out_kind         = bdee_pkg::KIND_HEARTBEAT;
    out_button_index = '0;
    out_servo_id     = bdee_pkg::HB_SERVO;
    dir_sel          = bdee_pkg::DIR_STOP;
    out_led_color    = '0;
    for (int i = 0; i < NB; i++) begin
      if (lowest[i]) begin
        out_kind         = bdee_pkg::KIND_BUTTON;
        out_button_index = bdee_pkg::IDX_W'(i);
        out_servo_id     = map_c[i].servo;
        dir_sel          = pressed_r[i] ? map_c[i].dir : bdee_pkg::DIR_STOP;
        out_led_color    = pressed_r[i] ? map_c[i].color : '0;
      end
    end
  end
  assign out_direction = $signed(dir_sel);

  // Pending mask: drop the sent bit, reload as the last leaves or when empty
  always_comb begin
    pend_nxt = pend_r;
    if (out_fire) begin
      pend_nxt = rest;
    end
    if (load_fire) begin
      pend_nxt = load.mask;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_fire) begin
      pressed_r <= load.pressed;
    end
  end

`ifndef SYNTH
  // A poll is only loaded once the previous one has fully drained
  a_load_after_drain: assert property (@(posedge clk) disable iff (!rst_n)
    load_fire |-> (!out_valid || (out_fire && out_last)))
    else $error("poll loaded over pending results");

  // Each sent result removes exactly one pending bit
  a_one_per_send: assert property (@(posedge clk) disable iff (!rst_n)
    (out_fire && !load_fire) |=> $countones(pend_r) == $countones($past(pend_r)) - 1)
    else $error("pending count did not drop by one");

  // Stalled output keeps its pending set
  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> $stable(pend_r))
    else $error("pending set changed under stall");
`endif

endmodule

>>> bench/tb.sv
// Testbench for button_debounce_event_encoder: poll requests in, command results out.
// Keeps its own model of the lockout and heartbeat logic and checks every result in order.
// Depends on bdee_pkg and button_debounce_event_encoder.
`timescale 1ns / 1ps

module tb;

  localparam int SETTLE_CYCLES = 4;     // input register plus first result, with margin
  localparam int TIMEOUT_NS    = 2_000_000;

  // Indexes past the two registers; writes there must be ignored
  localparam logic [bdee_pkg::CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [bdee_pkg::CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

  // Press colors, button 0 in the low bits
  localparam logic [bdee_pkg::NUM_BUTTONS*bdee_pkg::COLOR_W-1:0] KEY_COLORS =
    {24'h00FFFF, 24'hFF00FF, 24'hFFFF00, 24'h0000FF, 24'h00FF00, 24'hFF0000};

  typedef struct packed {
    logic                         kind;
    logic [bdee_pkg::IDX_W-1:0]   button;
    logic [bdee_pkg::SERVO_W-1:0] servo;
    logic [bdee_pkg::DIR_W-1:0]   dir;
    logic [bdee_pkg::COLOR_W-1:0] color;
    logic                         last;
  } command_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                             cfg_we = 1'b0;
  logic [bdee_pkg::CFG_IDX_W-1:0]   cfg_index = '0;
  logic [bdee_pkg::CFG_DATA_W-1:0]  cfg_data = '0;

  logic                             in_valid = 1'b0;
  logic                             in_ready;
  logic [bdee_pkg::TIME_BITS-1:0]   in_time_now = '0;
  logic [bdee_pkg::NUM_BUTTONS-1:0] in_raw_levels = '1;

  logic                              out_valid;
  logic                              out_ready = 1'b0;
  logic                              out_kind;
  logic [bdee_pkg::IDX_W-1:0]        out_button_index;
  logic [bdee_pkg::SERVO_W-1:0]      out_servo_id;
  logic signed [bdee_pkg::DIR_W-1:0] out_direction;
  logic [bdee_pkg::COLOR_W-1:0]      out_led_color;
  logic                              out_last;

  // Model state and register copies
  logic [bdee_pkg::NUM_BUTTONS-1:0] held_q = '0;
  logic [bdee_pkg::TIME_BITS-1:0]   change_ms [bdee_pkg::NUM_BUTTONS] = '{default: '0};
  logic [bdee_pkg::TIME_BITS-1:0]   heartbeat_at = '0;
  logic [bdee_pkg::DEB_W-1:0]       lockout_ms = bdee_pkg::DEBOUNCE_RESET;
  logic [bdee_pkg::HB_W-1:0]        heartbeat_ms = bdee_pkg::HEARTBEAT_RESET;

  command_t pending_cmds[$];
  command_t head_cmd;
  int       mismatch_count = 0;

  // Last poll sent and sender burst state
  logic [bdee_pkg::TIME_BITS-1:0]   poll_time = '0;
  logic [bdee_pkg::NUM_BUTTONS-1:0] poll_levels = '1;
  int                               burst_left = 0;

  // Receiver stall pattern
  logic [15:0] ready_pat = '0;
  int          pat_age = 0;

  button_debounce_event_encoder u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_time_now      (in_time_now),
    .in_raw_levels    (in_raw_levels),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_kind         (out_kind),
    .out_button_index (out_button_index),
    .out_servo_id     (out_servo_id),
    .out_direction    (out_direction),
    .out_led_color    (out_led_color),
    .out_last         (out_last)
  );

  always #5 clk = ~clk;

  // Works out the commands one poll causes and queues them
  function automatic void predict_commands(input logic [bdee_pkg::TIME_BITS-1:0] now,
                                           input logic [bdee_pkg::NUM_BUTTONS-1:0] levels);
    command_t cmds[$];
    command_t c;
    logic     pressed;
    for (int i = 0; i < bdee_pkg::NUM_BUTTONS; i++) begin
      pressed = ~levels[i];
      if (pressed != held_q[i] && (now - change_ms[i]) > lockout_ms) begin
        held_q[i] = pressed;
        change_ms[i] = now;
        c = '0;
        c.kind = bdee_pkg::KIND_BUTTON;
        c.button = bdee_pkg::IDX_W'(i);
        // each servo takes a pair of buttons: even turns it counterclockwise, odd clockwise
        c.servo = bdee_pkg::SERVO_W'(i / 2);
        if (pressed) begin
          c.dir = (i % 2 == 0) ? bdee_pkg::DIR_CCW : bdee_pkg::DIR_CW;
          c.color = KEY_COLORS[i*bdee_pkg::COLOR_W +: bdee_pkg::COLOR_W];
        end
        cmds.push_back(c);
      end
    end
    // heartbeat comes after all buttons
    if ((now - heartbeat_at) > heartbeat_ms) begin
      c = '0;
      c.kind = bdee_pkg::KIND_HEARTBEAT;
      c.servo = bdee_pkg::HB_SERVO;
      c.dir = bdee_pkg::DIR_STOP;
      cmds.push_back(c);
      heartbeat_at = now;
    end
    if (cmds.size() > 0)
      cmds[cmds.size()-1].last = 1'b1;
    foreach (cmds[k])
      pending_cmds.push_back(cmds[k]);
  endfunction

  function automatic void check_field(input string field, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
      mismatch_count++;
    end
  endfunction

  // Result checker: each accepted result against the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_cmds.size() == 0) begin
        $error("result with none expected: kind %0d button %0d", out_kind, out_button_index);
        mismatch_count++;
      end else begin
        head_cmd = pending_cmds.pop_front();
        check_field("kind", 32'(head_cmd.kind), 32'(out_kind));
        check_field("button_index", 32'(head_cmd.button), 32'(out_button_index));
        check_field("servo_id", 32'(head_cmd.servo), 32'(out_servo_id));
        check_field("direction", 32'(head_cmd.dir), 32'($unsigned(out_direction)));
        check_field("led_color", 32'(head_cmd.color), 32'(out_led_color));
        check_field("last", 32'(head_cmd.last), 32'(out_last));
      end
    end
  end

  // Receiver: shifting stall pattern, reloaded as pat_age runs out, sometimes no stalls
  always @(posedge clk) begin
    if (pat_age == 0) begin
      ready_pat <= ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom);
      pat_age <= 64;
    end else begin
      ready_pat <= {ready_pat[14:0], ready_pat[15]};
      pat_age <= pat_age - 1;
    end
    out_ready <= ready_pat[15];
  end

  // Sends one poll request in bursts with random gaps, then predicts its commands
  task automatic send_poll(input logic [bdee_pkg::TIME_BITS-1:0] t,
                           input logic [bdee_pkg::NUM_BUTTONS-1:0] lv);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = $urandom_range(1, 16);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_time_now <= t;
    in_raw_levels <= lv;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    poll_time = t;
    poll_levels = lv;
    predict_commands(t, lv);
  endtask

  // Holds the sender until every expected result is back and the block is quiet
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_cmds.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [bdee_pkg::CFG_IDX_W-1:0] idx,
                           input logic [bdee_pkg::CFG_DATA_W-1:0] data);
    wait_drained();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      bdee_pkg::CFG_DEBOUNCE:  lockout_ms = data[bdee_pkg::DEB_W-1:0];
      bdee_pkg::CFG_HEARTBEAT: heartbeat_ms = data[bdee_pkg::HB_W-1:0];
      default: ;
    endcase
  endtask

  // Random polls: mostly bounces around the lockout window, some big jumps and backward time
  task automatic random_polls(input int count);
    int                               mode;
    int                               sel;
    logic [bdee_pkg::TIME_BITS-1:0]   t;
    logic [bdee_pkg::NUM_BUTTONS-1:0] lv;
    logic [31:0]                      span;
    repeat (count) begin
      t = poll_time;
      lv = poll_levels;
      span = {16'b0, lockout_ms} * 2 + 4;
      mode = $urandom_range(0, 99);
      if (mode < 55)
        t = t + $urandom_range(0, span);
      else if (mode < 65)
        t = t;                                   // same timestamp again
      else if (mode < 80)
        t = t + $urandom_range(0, {12'b0, heartbeat_ms} + 8);
      else if (mode < 88)
        t = t - $urandom_range(0, span);
      else
        t = $urandom;
      mode = $urandom_range(0, 99);
      if (mode < 55) begin
        sel = $urandom_range(0, bdee_pkg::NUM_BUTTONS - 1);
        lv[sel] = ~lv[sel];
      end else if (mode < 75)
        lv = lv ^ bdee_pkg::NUM_BUTTONS'($urandom);
      else if (mode < 85)
        lv = bdee_pkg::NUM_BUTTONS'($urandom);
      send_poll(t, lv);
    end
  endtask

  // Presses inside the start-up lockout, exact lockout boundary, release
  task automatic test_startup_lockout();
    send_poll(32'd10,  6'h3E);
    send_poll(32'd50,  6'h3E);
    send_poll(32'd51,  6'h3E);
    send_poll(32'd60,  6'h3F);
    send_poll(32'd101, 6'h3F);
    send_poll(32'd102, 6'h3F);
  endtask

  // Every button at once, heartbeat boundary, seven results from one poll
  task automatic test_all_buttons_and_heartbeat();
    send_poll(32'd200,   6'h00);
    send_poll(32'd300,   6'h3F);
    send_poll(32'd5000,  6'h3F);
    send_poll(32'd5001,  6'h3F);
    send_poll(32'd10002, 6'h00);
  endtask

  // Timestamps across the wrap and going backwards
  task automatic test_wrapped_time();
    send_poll(32'hFFFF_FFF0, 6'h3F);
    send_poll(32'h0000_0010, 6'h00);
    send_poll(32'h0000_0023, 6'h00);
    send_poll(32'h0000_0010, 6'h2A);
    send_poll(32'hFFFF_FFFF, 6'h15);
  endtask

  task automatic test_register_sweep();
    // no lockout, heartbeat on every new timestamp
    write_reg(bdee_pkg::CFG_DEBOUNCE, '0);
    write_reg(bdee_pkg::CFG_HEARTBEAT, '0);
    random_polls(30);
    // widest values; the upper bits of the debounce write fall away
    write_reg(bdee_pkg::CFG_DEBOUNCE, '1);
    write_reg(bdee_pkg::CFG_HEARTBEAT, '1);
    random_polls(30);
    // spare indexes leave both registers alone
    write_reg(CFG_SPARE_A, bdee_pkg::CFG_DATA_W'($urandom));
    write_reg(CFG_SPARE_B, bdee_pkg::CFG_DATA_W'($urandom));
    random_polls(30);
    write_reg(bdee_pkg::CFG_DEBOUNCE,
              20'h10000 | bdee_pkg::CFG_DATA_W'($urandom_range(1, 200)));
    write_reg(bdee_pkg::CFG_HEARTBEAT, bdee_pkg::CFG_DATA_W'($urandom_range(0, 3000)));
    random_polls(30);
    write_reg(bdee_pkg::CFG_DEBOUNCE, 20'd1);
    write_reg(bdee_pkg::CFG_HEARTBEAT, 20'd1);
    random_polls(30);
  endtask

  task automatic test_random_traffic();
    write_reg(bdee_pkg::CFG_DEBOUNCE, bdee_pkg::CFG_DATA_W'(bdee_pkg::DEBOUNCE_RESET));
    write_reg(bdee_pkg::CFG_HEARTBEAT, bdee_pkg::CFG_DATA_W'(bdee_pkg::HEARTBEAT_RESET));
    random_polls(70);
    // sender holds until the block has emptied out
    wait_drained();
    write_reg(bdee_pkg::CFG_DEBOUNCE, bdee_pkg::CFG_DATA_W'($urandom_range(0, 300)));
    write_reg(bdee_pkg::CFG_HEARTBEAT, bdee_pkg::CFG_DATA_W'($urandom_range(0, 2000)));
    random_polls(100);
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_startup_lockout();
    test_all_buttons_and_heartbeat();
    test_wrapped_time();
    test_register_sweep();
    test_random_traffic();
    wait_drained();
    repeat (16) @(posedge clk);
    if (mismatch_count == 0 && pending_cmds.size() == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

  // Hang guard
  initial begin
    #(TIMEOUT_NS);
    $display("FAILED: results differ");
    $finish;
  end

endmodule

>>> button_debounce_event_encoder.f
hw/rtl/bdee_pkg.sv
hw/rtl/bdee_emit.sv
hw/rtl/button_debounce_event_encoder.sv
bench/tb.sv
